### hw/rtl/binary_merit_weighted_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Binary merit weighted scheduler assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_MERIT_WEIGHTED_SCHEDULER_DEFINES_SVH
`define BINARY_MERIT_WEIGHTED_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define BMWS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/bmws_pkg.sv
// ----------------------------------------------------------------------------
// Binary merit weighted scheduler package
// Operation codes, field widths and sequencer state type.
// ----------------------------------------------------------------------------
package bmws_pkg;

	localparam int ID_W    = 6;
	localparam int MERIT_W = 16;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK
	} state_t;

endpackage

### hw/rtl/bmws_find.sv
// ----------------------------------------------------------------------------
// Member search unit
// Finds the lowest set bit of a plane row at or above a start position.
// ----------------------------------------------------------------------------
module bmws_find #(
	parameter int W  = 64,
	parameter int SW = 7
) (
	input  logic [W-1:0]  vec,
	input  logic [SW-1:0] start,
	output logic          found,
	output logic [SW-1:0] idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		// descend so the lowest qualifying member wins
		for (int i = W - 1; i >= 0; i--) begin
			if (vec[i] && (SW'(i) >= start)) begin
				found = 1'b1;
				idx   = SW'(i);
			end
		end
	end

endmodule

### hw/rtl/binary_merit_weighted_scheduler.sv
// ----------------------------------------------------------------------------
// Binary merit weighted scheduler
// A merit write first updates the plane rows, then resets any plane it
// emptied. A next request first picks the top plane, and then the sequencer
// visits one plane per cycle: each walk descends the chain of non-executing
// planes until an executing plane searches its row, and up to four walks are
// made. The single member search unit and the lower-plane encoder are shared
// by every step. No item is taken while a result waits at the output.
// ----------------------------------------------------------------------------
`include "binary_merit_weighted_scheduler_defines.svh"

module binary_merit_weighted_scheduler
	import bmws_pkg::*;
#(
	parameter int ITEMS      = 64,
	parameter int MERIT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [ID_W-1:0]    item_id,
	input  logic [MERIT_W-1:0] merit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ID_W-1:0]    granted_item,
	output logic               none_active
);

	localparam int IW = (ITEMS > 1) ? $clog2(ITEMS) : 1;
	localparam int CW = IW + 1;
	localparam int PW = $clog2(MERIT_BITS);
	localparam int MB = MERIT_BITS;

	logic [ITEMS-1:0] member_q [MB];
	logic [MB-1:0]    exec_q;
	logic [MB-1:0]    pass_q [MB];
	logic [CW-1:0]    cursor_q [MB];

	state_t        state_q, state_d;
	logic [PW-1:0] p_q, top_q;
	logic [MB-1:0] path_q, drop_q;
	logic [1:0]    tries_q;

	logic            out_valid_q, none_q;
	logic [ID_W-1:0] item_q;

	logic            accept;
	logic [MB-1:0]   nonempty;
	logic            top_found, low_found;
	logic [PW-1:0]   top_idx, low_idx;
	logic [IW-1:0]   wid;
	logic            in_range;
	logic [MB-1:0]   old_m, new_m, clr_mask;
	logic [CW-1:0]   cur, start;
	logic            hit;
	logic [CW-1:0]   hit_idx;
	logic            pass_done;
	logic [MB:0]     rep;
	logic [PW-1:0]   gap;
	logic            fail, step_down, last_try;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign wid      = IW'(item_id);
	assign in_range = 32'(item_id) < 32'(ITEMS);
	assign new_m    = MB'(merit);

	always_comb begin
		for (int p = 0; p < MB; p++) begin
			nonempty[p] = |member_q[p];
			old_m[p]    = member_q[p][wid];
		end
	end

	always_comb begin
		top_found = 1'b0;
		top_idx   = '0;
		low_found = 1'b0;
		low_idx   = '0;
		for (int p = 0; p < MB; p++) begin
			if (nonempty[p]) begin
				top_found = 1'b1;
				top_idx   = PW'(p);
			end
			if (nonempty[p] && (PW'(p) < p_q)) begin
				low_found = 1'b1;
				low_idx   = PW'(p);
			end
		end
	end

	assign cur   = cursor_q[p_q];
	assign start = (cur >= CW'(ITEMS)) ? '0 : cur + 1'b1;

	bmws_find #(.W(ITEMS), .SW(CW)) u_find (
		.vec   (member_q[p_q]),
		.start (start),
		.found (hit),
		.idx   (hit_idx)
	);

	// repeat count is 2^gap; the lowest plane repeats once
	assign gap       = p_q - low_idx - 1'b1;
	assign rep       = (MB + 1)'(1) << gap;
	assign pass_done = !low_found || (({1'b0, pass_q[p_q]} + 1'b1) >= rep);

	always_comb begin
		state_d   = state_q;
		fail      = 1'b0;
		step_down = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_SET) state_d = ST_CLEAR;
					else if (top_found) state_d = ST_WALK;
				end
			end
			ST_CLEAR: state_d = ST_IDLE;
			ST_WALK: begin
				if (!exec_q[p_q]) begin
					if (low_found) step_down = 1'b1;
					else fail = 1'b1;
				end else if (!hit) begin
					fail = 1'b1;
				end
				if ((exec_q[p_q] && hit) || (fail && last_try)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign last_try = (tries_q == 2'd3);
	assign clr_mask = path_q | ((!exec_q[p_q]) ? (MB'(1) << p_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			none_q      <= 1'b0;
			item_q      <= '0;
			p_q         <= '0;
			top_q       <= '0;
			path_q      <= '0;
			drop_q      <= '0;
			tries_q     <= '0;
			exec_q      <= '1;
			for (int p = 0; p < MB; p++) begin
				member_q[p] <= '0;
				pass_q[p]   <= '0;
				cursor_q[p] <= CW'(ITEMS);
			end
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_SET) begin
						drop_q <= in_range ? (old_m & ~new_m) : '0;
						if (in_range) begin
							for (int p = 0; p < MB; p++) member_q[p][wid] <= new_m[p];
						end
					end else if (accept) begin
						top_q   <= top_idx;
						p_q     <= top_idx;
						path_q  <= '0;
						tries_q <= '0;
						if (!top_found) begin
							out_valid_q <= 1'b1;
							none_q      <= 1'b1;
							item_q      <= '0;
						end
					end
				end
				ST_CLEAR: begin
					// reset planes the write emptied
					for (int p = 0; p < MB; p++) begin
						if (drop_q[p] && !nonempty[p]) begin
							exec_q[p]   <= 1'b1;
							pass_q[p]   <= '0;
							cursor_q[p] <= CW'(ITEMS);
						end
					end
				end
				ST_WALK: begin
					if (exec_q[p_q]) begin
						if (hit) begin
							cursor_q[p_q] <= hit_idx;
							out_valid_q   <= 1'b1;
							none_q        <= 1'b0;
							item_q        <= ID_W'(hit_idx);
						end else begin
							cursor_q[p_q] <= CW'(ITEMS);
							pass_q[p_q]   <= pass_q[p_q] + 1'b1;
							if (pass_done) exec_q[p_q] <= 1'b0;
						end
					end else if (step_down) begin
						path_q[p_q] <= 1'b1;
						p_q         <= low_idx;
					end
					if (fail) begin
						// turn ended: reset every plane that handed down, and the current plane if it is not executing
						for (int p = 0; p < MB; p++) begin
							if (clr_mask[p]) begin
								exec_q[p]   <= 1'b1;
								pass_q[p]   <= '0;
								cursor_q[p] <= CW'(ITEMS);
							end
						end
						tries_q <= tries_q + 1'b1;
						p_q     <= top_q;
						path_q  <= '0;
						if (last_try) begin
							out_valid_q <= 1'b1;
							none_q      <= 1'b0;
							item_q      <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_item = item_q;
	assign none_active  = none_q;

	`BMWS_ASSERT_IMPL(a_none_zero, out_valid && none_active, granted_item == '0, "none_active with nonzero item")
	`BMWS_ASSERT_NEXT(a_accept_busy, accept, (state_q != ST_IDLE) || out_valid, "accepted item left no trace")
	`BMWS_ASSERT_IMPL(a_walk_empty_out, state_q == ST_WALK, !out_valid_q, "walk with result pending")

endmodule
